// ===== rtl/blr_pkg.sv =====
// shared types, widths and helpers of the line rasterizer
package blr_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CLIP_BITS    = 11;
  localparam int COLOR_BITS   = 24;
  localparam int DELTA_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS     = COORD_BITS + 3;
  localparam int CMP_BITS     = (COORD_BITS > CLIP_BITS + 1) ? COORD_BITS : CLIP_BITS + 1;
  localparam int REG_IDX_BITS = 1;

  localparam logic [CLIP_BITS-1:0] CLIP_RESET = CLIP_BITS'(800);

  // item operation codes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_CLIP_WIDTH  = 1'b0,
    REG_CLIP_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                          operation;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0]        line_color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         on_screen;
    logic                         last;
  } out_item_t;

  // running line state
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cursor_x;
    logic signed [COORD_BITS-1:0] cursor_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic [DELTA_BITS-1:0]        abs_delta_x;
    logic signed [DELTA_BITS-1:0] neg_abs_delta_y;
    logic                         step_x_negative;
    logic                         step_y_negative;
    logic signed [ERR_BITS-1:0]   error_term;
    logic [COLOR_BITS-1:0]        held_color;
    logic                         line_active;
  } line_state_t;

  // true when 0 <= c < lim
  function automatic logic on_axis(input logic signed [COORD_BITS-1:0] c,
                                   input logic [CLIP_BITS-1:0] lim);
    return !c[COORD_BITS-1] &&
           (CMP_BITS'($unsigned(c)) < CMP_BITS'(lim));
  endfunction

endpackage

// ===== rtl/bresenham_line_rasterizer.sv =====
// All-octant Bresenham line generator with a clip flag. A start item loads the endpoints
// and colour and produces no pixel; each advance item while a line is active produces one
// pixel, the last one flagged, and an advance while idle produces nothing. The block takes
// one item per clock unless stalled, and a pixel appears on the output in the cycle after
// its advance item is accepted, formed by the combinational step logic from the line state
// registers. The input is stalled only while a finished pixel waits in the result register
// and the sink is not ready. Clip width and height reset to 800; the user must write them
// through the configuration port only while the block is idle, which it does not enforce.
module bresenham_line_rasterizer
  import blr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_item,
  input  logic                    cfg_we,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [CLIP_BITS-1:0]    cfg_data
);

  logic [CLIP_BITS-1:0] clip_width_r;
  logic [CLIP_BITS-1:0] clip_height_r;
  line_state_t          st_r;
  line_state_t          st_nxt;
  logic                 emit;
  out_item_t            pix;
  logic                 in_fire;

  assign in_fire = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_width_r  <= CLIP_RESET;
      clip_height_r <= CLIP_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLIP_WIDTH:  clip_width_r  <= cfg_data;
        REG_CLIP_HEIGHT: clip_height_r <= cfg_data;
        default: begin
          clip_width_r <= clip_width_r;
        end
      endcase
    end
  end

  // step datapath
  blr_step u_step (
    .st          (st_r),
    .item        (in_item),
    .clip_width  (clip_width_r),
    .clip_height (clip_height_r),
    .st_nxt      (st_nxt),
    .emit        (emit),
    .pix         (pix)
  );

  // line state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  blr_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .emit      (emit),
    .pix       (pix),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // an advance on an active line always yields a pixel next cycle
  a_advance_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_item.operation == OP_ADVANCE && st_r.line_active |=> out_valid)
    else $error("advance on active line produced no pixel");

  // an advance while idle yields nothing
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_item.operation == OP_ADVANCE && !st_r.line_active |=> !out_valid)
    else $error("advance while idle produced a pixel");

  // a start always leaves a line active
  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_item.operation == OP_START |=> st_r.line_active)
    else $error("start did not activate a line");

  // the line is idle while its last pixel is shown
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !st_r.line_active)
    else $error("line still active after last pixel");

endmodule

// ===== rtl/blr_step.sv =====
// line setup and one bresenham error-term step, combinational
module blr_step
  import blr_pkg::*;
(
  input  line_state_t          st,
  input  in_item_t             item,
  input  logic [CLIP_BITS-1:0] clip_width,
  input  logic [CLIP_BITS-1:0] clip_height,
  output line_state_t          st_nxt,
  output logic                 emit,
  output out_item_t            pix
);

  logic signed [DELTA_BITS-1:0] dx;
  logic signed [DELTA_BITS-1:0] dy;
  logic [DELTA_BITS-1:0]        abs_dx;
  logic signed [DELTA_BITS-1:0] neg_ady;
  logic signed [ERR_BITS:0]     twice;
  logic                         move_x;
  logic                         move_y;
  logic                         fin;
  logic signed [ERR_BITS-1:0]   add_x;
  logic signed [ERR_BITS-1:0]   add_y;

  // endpoint deltas for a new line
  always_comb begin
    dx      = DELTA_BITS'(item.end_x) - DELTA_BITS'(item.start_x);
    dy      = DELTA_BITS'(item.end_y) - DELTA_BITS'(item.start_y);
    abs_dx  = dx[DELTA_BITS-1] ? $unsigned(-dx) : $unsigned(dx);
    neg_ady = dy[DELTA_BITS-1] ? dy : -dy;
  end

  // step decisions from the doubled error term
  always_comb begin
    fin    = (st.cursor_x == st.target_x) && (st.cursor_y == st.target_y);
    twice  = $signed({st.error_term, 1'b0});
    move_x = twice >= (ERR_BITS+1)'(st.neg_abs_delta_y);
    move_y = twice <= $signed((ERR_BITS+1)'(st.abs_delta_x));
    add_x  = move_x ? ERR_BITS'(st.neg_abs_delta_y) : '0;
    add_y  = move_y ? $signed(ERR_BITS'(st.abs_delta_x)) : '0;
  end

  // emitted pixel
  always_comb begin
    pix.pixel_x     = st.cursor_x;
    pix.pixel_y     = st.cursor_y;
    pix.pixel_color = st.held_color;
    pix.on_screen   = on_axis(st.cursor_x, clip_width) && on_axis(st.cursor_y, clip_height);
    pix.last        = fin;
  end

  // next state for the accepted item
  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    unique case (item.operation)
      OP_START: begin
        st_nxt.cursor_x        = item.start_x;
        st_nxt.cursor_y        = item.start_y;
        st_nxt.target_x        = item.end_x;
        st_nxt.target_y        = item.end_y;
        st_nxt.abs_delta_x     = abs_dx;
        st_nxt.neg_abs_delta_y = neg_ady;
        st_nxt.step_x_negative = !(item.start_x < item.end_x);
        st_nxt.step_y_negative = !(item.start_y < item.end_y);
        st_nxt.error_term      = $signed(ERR_BITS'(abs_dx)) + ERR_BITS'(neg_ady);
        st_nxt.held_color      = item.line_color;
        st_nxt.line_active     = 1'b1;
      end
      OP_ADVANCE: begin
        if (st.line_active) begin
          emit = 1'b1;
          if (fin) begin
            st_nxt.line_active = 1'b0;
          end else begin
            st_nxt.error_term = st.error_term + add_x + add_y;
            if (move_x) begin
              st_nxt.cursor_x = st.step_x_negative ? st.cursor_x - 1'b1
                                                   : st.cursor_x + 1'b1;
            end
            if (move_y) begin
              st_nxt.cursor_y = st.step_y_negative ? st.cursor_y - 1'b1
                                                   : st.cursor_y + 1'b1;
            end
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

// ===== rtl/blr_outreg.sv =====
// result register with valid/ready handshake toward the pixel sink
module blr_outreg
  import blr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  logic      emit,
  input  out_item_t pix,
  output logic      can_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  // register is free when empty or being drained this cycle
  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_take) begin
      valid_nxt = load && emit;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load && emit) begin
      item_r <= pix;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== sim/tb_bresenham_line_rasterizer.sv =====
// self-checking testbench of the bresenham line rasterizer
module tb_bresenham_line_rasterizer;
  import blr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = '0;
  logic [CLIP_BITS-1:0] cfg_data = '0;

  // pixels predicted but not yet seen on the output
  out_item_t expected_pixels[$];
  int errors = 0;
  int cycle_count = 0;
  int rx_hold = 1;
  // when set, neither side inserts wait cycles
  logic calm = 1'b0;

  // predicted line state and clip window
  logic signed [COORD_BITS-1:0] trk_x = '0;
  logic signed [COORD_BITS-1:0] trk_y = '0;
  logic signed [COORD_BITS-1:0] dst_x = '0;
  logic signed [COORD_BITS-1:0] dst_y = '0;
  logic [DELTA_BITS-1:0] span_x = '0;
  logic signed [DELTA_BITS-1:0] span_y_neg = '0;
  logic x_back = 1'b0;
  logic y_back = 1'b0;
  logic signed [ERR_BITS-1:0] err_acc = '0;
  logic [COLOR_BITS-1:0] ink = '0;
  logic line_on = 1'b0;
  logic [CLIP_BITS-1:0] clip_w = CLIP_RESET;
  logic [CLIP_BITS-1:0] clip_h = CLIP_RESET;

  bresenham_line_rasterizer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // advance the predicted line by one accepted item
  task automatic rasterize_item(input in_item_t it);
    int x0, y0, x1, y1, dx, dy, e, ax, ny, twice, cx, cy;
    logic on, fin;
    out_item_t px;
    if (it.operation == OP_START) begin
      x0 = int'(it.start_x);
      y0 = int'(it.start_y);
      x1 = int'(it.end_x);
      y1 = int'(it.end_y);
      dx = x1 - x0;
      dy = y1 - y0;
      trk_x = it.start_x;
      trk_y = it.start_y;
      dst_x = it.end_x;
      dst_y = it.end_y;
      span_x = DELTA_BITS'(dx < 0 ? -dx : dx);
      span_y_neg = DELTA_BITS'(dy < 0 ? dy : -dy);
      x_back = !(x0 < x1);
      y_back = !(y0 < y1);
      ax = int'(span_x);
      ny = int'(span_y_neg);
      err_acc = ERR_BITS'(ax + ny);
      ink = it.line_color;
      line_on = 1'b1;
    end else if (line_on) begin
      cx = int'(trk_x);
      cy = int'(trk_y);
      on = cx >= 0 && cx < int'(clip_w) && cy >= 0 && cy < int'(clip_h);
      fin = (trk_x == dst_x) && (trk_y == dst_y);
      px.pixel_x = trk_x;
      px.pixel_y = trk_y;
      px.pixel_color = ink;
      px.on_screen = on;
      px.last = fin;
      expected_pixels.push_back(px);
      if (fin) begin
        line_on = 1'b0;
      end else begin
        e = int'(err_acc);
        ax = int'(span_x);
        ny = int'(span_y_neg);
        twice = 2 * e;
        if (twice >= ny) begin
          e += ny;
          cx += x_back ? -1 : 1;
        end
        if (twice <= ax) begin
          e += ax;
          cy += y_back ? -1 : 1;
        end
        err_acc = ERR_BITS'(e);
        trk_x = COORD_BITS'(cx);
        trk_y = COORD_BITS'(cy);
      end
    end
  endtask

  // offer one item after a random gap and predict it once accepted
  task automatic send_item(input in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    rasterize_item(it);
  endtask

  // hold the input off until every predicted pixel has arrived
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  task automatic wait_idle();
    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CLIP_BITS-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_CLIP_WIDTH) clip_w = val;
    else clip_h = val;
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation = op_t'($urandom_range(0, 1));
    it.start_x = COORD_BITS'($urandom());
    it.start_y = COORD_BITS'($urandom());
    it.end_x = COORD_BITS'($urandom());
    it.end_y = COORD_BITS'($urandom());
    it.line_color = COLOR_BITS'($urandom());
    return it;
  endfunction

  task automatic start_line(input int x0, input int y0, input int x1, input int y1,
                            input logic [COLOR_BITS-1:0] color);
    in_item_t it;
    it = random_item();
    it.operation = OP_START;
    it.start_x = COORD_BITS'(x0);
    it.start_y = COORD_BITS'(y0);
    it.end_x = COORD_BITS'(x1);
    it.end_y = COORD_BITS'(y1);
    it.line_color = color;
    send_item(it);
  endtask

  // advance items carry random, ignored endpoint fields
  task automatic advance_pixel();
    in_item_t it;
    it = random_item();
    it.operation = OP_ADVANCE;
    send_item(it);
  endtask

  function automatic int clamp_coord(input int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // mostly near the clip window, sometimes anywhere
  function automatic int pick_coord(input int lim);
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 4095)) - 2048;
    return clamp_coord(int'($urandom_range(0, lim + 32)) - 16);
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
  endtask

  // result side: random stalls, compare each pixel with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 1;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d",
                   $realtime, out_item.pixel_x, out_item.pixel_y);
        end else begin
          want = expected_pixels.pop_front();
          if (out_item.pixel_x !== want.pixel_x)
            report_field("pixel_x", int'(want.pixel_x), int'(out_item.pixel_x));
          if (out_item.pixel_y !== want.pixel_y)
            report_field("pixel_y", int'(want.pixel_y), int'(out_item.pixel_y));
          if (out_item.pixel_color !== want.pixel_color)
            report_field("pixel_color", int'(want.pixel_color), int'(out_item.pixel_color));
          if (out_item.on_screen !== want.on_screen)
            report_field("on_screen", int'(want.on_screen), int'(out_item.on_screen));
          if (out_item.last !== want.last)
            report_field("last", int'(want.last), int'(out_item.last));
        end
        w = calm ? 0 : $urandom_range(0, 6);
        out_ready <= (w == 0);
        rx_hold <= w;
      end else if (!out_ready) begin
        if (rx_hold <= 1) out_ready <= 1'b1;
        rx_hold <= rx_hold - 1;
      end
    end
  end

  // idle advances, single-pixel lines, clip boundary pixels
  task automatic test_idle_and_single();
    advance_pixel();
    start_line(0, 0, 0, 0, 24'hFFFFFF);
    advance_pixel();
    advance_pixel();
    start_line(799, 799, 799, 799, 24'h000000);
    advance_pixel();
    start_line(800, -1, 800, -1, 24'hA5A5A5);
    advance_pixel();
  endtask

  // full-range endpoints, and a start that abandons a running line
  task automatic test_extreme_lines();
    start_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 24'h123456);
    advance_pixel();
    advance_pixel();
    start_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 24'hEDCBA9);
    advance_pixel();
    advance_pixel();
  endtask

  // shallow line across the clip edge with a pause in the middle, then a steep one
  task automatic test_octants_and_pause();
    start_line(798, 799, 801, 797, 24'h00FF00);
    advance_pixel();
    advance_pixel();
    drain_pixels();
    advance_pixel();
    advance_pixel();
    start_line(0, 0, 1, -3, 24'hFF0000);
    repeat (4) advance_pixel();
  endtask

  // mostly complete lines with random content, some cut short, some idle advances
  task automatic run_random_lines(input int n_items, input logic quiet);
    int sent, budget, x0, y0, len;
    sent = 0;
    while (sent < n_items) begin
      calm = quiet || ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // random item of either kind, full-range fields
        send_item(random_item());
        sent++;
      end
      len = $urandom_range(0, 12);
      x0 = pick_coord(int'(clip_w));
      y0 = pick_coord(int'(clip_h));
      start_line(x0, y0,
                 clamp_coord(x0 + int'($urandom_range(0, 2 * len)) - len),
                 clamp_coord(y0 + int'($urandom_range(0, 2 * len)) - len),
                 COLOR_BITS'($urandom()));
      sent++;
      budget = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 40;
      while (line_on && budget > 0) begin
        if ($urandom_range(0, 60) == 0) drain_pixels();
        advance_pixel();
        sent++;
        budget--;
      end
      if ($urandom_range(0, 3) == 0) begin
        advance_pixel();
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // random lines under several clip windows, extremes and zero among them
  task automatic test_clip_settings();
    run_random_lines(80, 1'b0);
    write_reg(REG_CLIP_WIDTH, 11'd2047);
    write_reg(REG_CLIP_HEIGHT, 11'd2047);
    run_random_lines(60, 1'b0);
    write_reg(REG_CLIP_WIDTH, 11'd1);
    write_reg(REG_CLIP_HEIGHT, 11'd1);
    run_random_lines(60, 1'b0);
    write_reg(REG_CLIP_WIDTH, 11'd0);
    write_reg(REG_CLIP_HEIGHT, 11'd0);
    run_random_lines(40, 1'b0);
    write_reg(REG_CLIP_WIDTH, CLIP_BITS'($urandom_range(1, 2047)));
    write_reg(REG_CLIP_HEIGHT, CLIP_BITS'($urandom_range(1, 2047)));
    run_random_lines(60, 1'b1);
    write_reg(REG_CLIP_WIDTH, 11'd640);
    write_reg(REG_CLIP_HEIGHT, 11'd480);
    run_random_lines(80, 1'b0);
  endtask

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_single();
    test_extreme_lines();
    test_octants_and_pause();
    test_clip_settings();
    drain_pixels();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== bresenham_line_rasterizer.f =====
rtl/blr_pkg.sv
rtl/blr_step.sv
rtl/blr_outreg.sv
rtl/bresenham_line_rasterizer.sv
sim/tb_bresenham_line_rasterizer.sv
